// File: design/cbk_pkg.sv
// Shared types and constants for the sliding-window circuit breaker.
// Used by cbk_ctrl, cbk_dpath and sliding_window_circuit_breaker; no dependencies.
package cbk_pkg;

   localparam int NUM_BREAKERS_DEF = 16;
   localparam int DEPTH_DEF        = 16;

   localparam int IDX_W  = 4;
   localparam int TIME_W = 32;
   localparam int KIND_W = 2;
   localparam int THR_W  = 5;
   localparam int HELD_W = 5;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [THR_W-1:0]  THR_RESET = 5'd5;
   localparam logic [TIME_W-1:0] WIN_RESET = 32'd30000;

   localparam logic [KIND_W-1:0] REQ_ADMIT = 2'd0;
   localparam logic [KIND_W-1:0] REQ_FAIL  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd2;

   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_WINDOW    = 1'b1;

   typedef enum logic [1:0] {
      MODE_CLOSED = 2'd0,
      MODE_OPEN   = 2'd1,
      MODE_HALF   = 2'd2
   } mode_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
      logic evict;
      logic record;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_fail;
      logic evict_more;
      logic out_free;
   } sts_type;

endpackage

// File: design/cbk_ctrl.sv
// Sequencer for the circuit breaker: clearing pass, execute, ring walk, record, deliver.
// Depends on cbk_pkg for command and status types.
module cbk_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  cbk_pkg::sts_type sts,
   output cbk_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_EVICT,
      ST_RECORD,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_fail ? ST_EVICT : ST_DELIVER;
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            if (!sts.evict_more) begin
               state_in = ST_RECORD;
            end
         end
         ST_RECORD: begin
            cmd.record = 1'b1;
            state_in   = ST_DELIVER;
         end
         ST_DELIVER: begin
            cmd.deliver = sts.out_free;
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $past(req_tvalid && req_tready))
      else $error("execute without an accepted transaction");

   a_accept_after_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> sts.clear_done)
      else $error("transaction accepted before the clearing pass ended");

   a_record_after_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RECORD) |-> ($past(state_ff) == ST_EVICT && !$past(sts.evict_more)))
      else $error("record entered without a finished ring walk");
`endif

endmodule

// File: design/cbk_dpath.sv
// Datapath for the circuit breaker: breaker store, open times, failure ring memory,
// working registers and the result register. Depends on cbk_pkg.
module cbk_dpath #(
   parameter int NUM_BREAKERS = cbk_pkg::NUM_BREAKERS_DEF,
   parameter int DEPTH        = cbk_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cbk_pkg::cmd_type                cmd,
   output cbk_pkg::sts_type                sts,
   input  logic [cbk_pkg::KIND_W-1:0]      req_kind,
   input  logic [cbk_pkg::IDX_W-1:0]       req_index,
   input  logic [cbk_pkg::TIME_W-1:0]      req_time,
   input  logic [cbk_pkg::THR_W-1:0]       threshold,
   input  logic [cbk_pkg::TIME_W-1:0]      window,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cbk_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int B_W    = (NUM_BREAKERS > 1) ? $clog2(NUM_BREAKERS) : 1;
   localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int RING_N = NUM_BREAKERS * DEPTH;
   localparam int RA_W   = (RING_N > 1) ? $clog2(RING_N) : 1;
   localparam int TW     = cbk_pkg::TIME_W;
   localparam int HW     = cbk_pkg::HELD_W;

   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(DEPTH);
   localparam logic [B_W-1:0]    CLR_LAST  = B_W'(NUM_BREAKERS - 1);

   cbk_pkg::mode_type mode_mem   [NUM_BREAKERS];
   logic              probe_mem  [NUM_BREAKERS];
   logic [HEAD_W-1:0] head_mem   [NUM_BREAKERS];
   logic [CNT_W-1:0]  count_mem  [NUM_BREAKERS];
   logic [TW-1:0]     opened_mem [NUM_BREAKERS];
   logic [TW-1:0]     ring_mem   [RING_N];

   logic [cbk_pkg::KIND_W-1:0] kind_ff;
   logic [TW-1:0]              time_ff;
   logic [B_W-1:0]             addr_ff;
   logic [RA_W-1:0]            base_ff;
   logic                       in_range_ff;
   cbk_pkg::mode_type          mode_ff;
   logic                       probe_ff;
   logic [HEAD_W-1:0]          head_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [TW-1:0]              opened_ff;
   logic [TW-1:0]              ring_rd_ff;
   logic                       res_blocked_ff;
   cbk_pkg::mode_type          res_mode_ff;
   logic [HW-1:0]              res_held_ff;
   logic [B_W-1:0]             clr_cnt_ff;
   logic                       rsp_valid_ff;
   logic [cbk_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   logic [B_W-1:0]    req_addr;
   logic              req_in_range;
   logic [TW-1:0]     elapsed;
   logic              expired;
   logic [TW-1:0]     age;
   logic              evict_more;
   logic [HEAD_W-1:0] head_inc;
   logic [RA_W-1:0]   ring_rd_addr;
   logic [RA_W-1:0]   ring_wr_addr;
   logic              state_wr;

   cbk_pkg::mode_type nx_mode;
   logic              nx_probe;
   logic [HEAD_W-1:0] nx_head;
   logic [CNT_W-1:0]  nx_count;
   logic              nx_blocked;

   logic              full;
   logic [HEAD_W-1:0] rec_head;
   logic [CNT_W-1:0]  rec_count;
   logic [CNT_W-1:0]  rec_count_new;
   logic [SUM_W-1:0]  slot_sum;
   logic [HEAD_W-1:0] slot;
   logic              rec_open;
   cbk_pkg::mode_type rec_mode;

   assign req_addr     = B_W'(req_index);
   assign req_in_range = (32'(req_index) < 32'(NUM_BREAKERS));

   assign elapsed    = time_ff - opened_ff;
   assign expired    = (elapsed >= window);
   assign age        = time_ff - ring_rd_ff;
   assign evict_more = (count_ff != '0) && (age > window);
   assign head_inc   = (head_ff == HEAD_LAST) ? '0 : head_ff + HEAD_W'(1);

   assign ring_rd_addr = base_ff + RA_W'(cmd.evict ? head_inc : head_ff);

   always_comb begin
      nx_mode    = mode_ff;
      nx_probe   = probe_ff;
      nx_head    = head_ff;
      nx_count   = count_ff;
      nx_blocked = 1'b0;
      if (kind_ff == cbk_pkg::REQ_ADMIT) begin
         unique case (mode_ff)
            cbk_pkg::MODE_CLOSED: begin
               nx_blocked = 1'b0;
            end
            cbk_pkg::MODE_OPEN: begin
               if (expired) begin
                  nx_mode  = cbk_pkg::MODE_HALF;
                  nx_probe = 1'b1;
               end else begin
                  nx_blocked = 1'b1;
               end
            end
            cbk_pkg::MODE_HALF: begin
               if (probe_ff) begin
                  nx_blocked = 1'b1;
               end else begin
                  nx_probe = 1'b1;
               end
            end
            default: begin
               nx_blocked = 1'b1;
            end
         endcase
      end else if (kind_ff == cbk_pkg::REQ_CLEAR) begin
         nx_mode  = cbk_pkg::MODE_CLOSED;
         nx_probe = 1'b0;
         nx_head  = '0;
         nx_count = '0;
      end
   end

   // drop the oldest entry when the ring is full, then append
   assign full          = (count_ff == CNT_FULL);
   assign rec_head      = full ? head_inc : head_ff;
   assign rec_count     = full ? count_ff - CNT_W'(1) : count_ff;
   assign slot_sum      = SUM_W'(rec_head) + SUM_W'(rec_count);
   assign slot          = HEAD_W'((slot_sum >= SUM_DEPTH) ? slot_sum - SUM_DEPTH : slot_sum);
   assign rec_count_new = rec_count + CNT_W'(1);
   assign rec_open      = (32'(rec_count_new) >= 32'(threshold));
   assign rec_mode      = rec_open ? cbk_pkg::MODE_OPEN : mode_ff;
   assign ring_wr_addr  = base_ff + RA_W'(slot);

   assign state_wr = cmd.exec && in_range_ff && (kind_ff != cbk_pkg::REQ_FAIL);

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mode_mem[clr_cnt_ff]  <= cbk_pkg::MODE_CLOSED;
         probe_mem[clr_cnt_ff] <= 1'b0;
         head_mem[clr_cnt_ff]  <= '0;
         count_mem[clr_cnt_ff] <= '0;
      end else if (state_wr) begin
         mode_mem[addr_ff]  <= nx_mode;
         probe_mem[addr_ff] <= nx_probe;
         head_mem[addr_ff]  <= nx_head;
         count_mem[addr_ff] <= nx_count;
      end else if (cmd.record) begin
         mode_mem[addr_ff]  <= rec_mode;
         probe_mem[addr_ff] <= probe_ff;
         head_mem[addr_ff]  <= rec_head;
         count_mem[addr_ff] <= rec_count_new;
      end

      if (cmd.record && rec_open) begin
         opened_mem[addr_ff] <= time_ff;
      end
      if (cmd.record) begin
         ring_mem[ring_wr_addr] <= time_ff;
      end

      if (cmd.exec || cmd.evict) begin
         ring_rd_ff <= ring_mem[ring_rd_addr];
      end

      if (cmd.accept) begin
         kind_ff     <= req_kind;
         time_ff     <= req_time;
         addr_ff     <= req_addr;
         base_ff     <= RA_W'(req_addr) * RA_W'(DEPTH);
         in_range_ff <= req_in_range;
         mode_ff     <= mode_mem[req_addr];
         probe_ff    <= probe_mem[req_addr];
         head_ff     <= head_mem[req_addr];
         count_ff    <= count_mem[req_addr];
         opened_ff   <= opened_mem[req_addr];
      end else if (cmd.evict && evict_more) begin
         head_ff  <= head_inc;
         count_ff <= count_ff - CNT_W'(1);
      end

      if (cmd.exec && !sts.is_fail) begin
         res_blocked_ff <= in_range_ff ? nx_blocked : 1'b0;
         res_mode_ff    <= in_range_ff ? nx_mode : cbk_pkg::MODE_CLOSED;
         res_held_ff    <= in_range_ff ? HW'(nx_count) : '0;
      end else if (cmd.record) begin
         res_blocked_ff <= 1'b0;
         res_mode_ff    <= rec_mode;
         res_held_ff    <= HW'(rec_count_new);
      end

      if (cmd.deliver) begin
         rsp_data_ff <= {res_held_ff, res_mode_ff, res_blocked_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear && !sts.clear_done) begin
            clr_cnt_ff <= clr_cnt_ff + B_W'(1);
         end
         if (cmd.deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clear_done = (clr_cnt_ff == CLR_LAST);
   assign sts.is_fail    = in_range_ff && (kind_ff == cbk_pkg::REQ_FAIL);
   assign sts.evict_more = evict_more;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> (count_ff <= CNT_FULL))
      else $error("ring count above depth");

   a_evict_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.evict && evict_more) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("dropped entry not taken off the ring count");

   a_deliver_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |=> (rsp_valid_ff && rsp_data_ff == $past({res_held_ff, res_mode_ff,
                                                               res_blocked_ff})))
      else $error("result not presented after delivery");
`endif

endmodule

// File: design/sliding_window_circuit_breaker.sv
// Table of sliding-window circuit breakers, one transaction in and one result out per
// request. After reset a clearing pass over all breakers runs before the first request
// is taken; configuration writes are accepted throughout. An admission check, a success or
// an unused request passes through accept, execute and deliver. A failure passes through
// accept, execute, a ring walk that drops each expired failure time from the breaker's ring,
// record and deliver; the ring memory is walked one entry a cycle through its single read port.
// One request is in flight at a time; a finished result waits in the output register while
// the next request is taken. Top level; depends on cbk_pkg, cbk_ctrl and cbk_dpath.
module sliding_window_circuit_breaker #(
   parameter int NUM_BREAKERS = cbk_pkg::NUM_BREAKERS_DEF,
   parameter int DEPTH        = cbk_pkg::DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cbk_pkg::REQ_TDATA_W-1:0]  req_tdata,   // breaker_index[3:0], time_ms[35:4], zero
   input  logic [cbk_pkg::KIND_W-1:0]       req_tuser,   // req_type[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cbk_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // blocked[0], breaker_mode_out[2:1],
                                                         // failures_held[7:3]
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cbk_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cbk_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cbk_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int IW = cbk_pkg::IDX_W;
   localparam int TW = cbk_pkg::TIME_W;

   logic [cbk_pkg::THR_W-1:0] thr_ff;
   logic [TW-1:0]             win_ff;
   logic                      csr_wr;

   cbk_pkg::cmd_type cmd;
   cbk_pkg::sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= cbk_pkg::THR_RESET;
         win_ff <= cbk_pkg::WIN_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == cbk_pkg::REG_THRESHOLD) begin
            thr_ff <= csr_pwdata[cbk_pkg::THR_W-1:0];
         end else begin
            win_ff <= csr_pwdata[TW-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == cbk_pkg::REG_WINDOW) ? win_ff
                                                             : cbk_pkg::CSR_DATA_W'(thr_ff);

   cbk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cbk_dpath #(
      .NUM_BREAKERS (NUM_BREAKERS),
      .DEPTH        (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_kind   (req_tuser),
      .req_index  (req_tdata[IW-1:0]),
      .req_time   (req_tdata[IW+TW-1:IW]),
      .threshold  (thr_ff),
      .window     (win_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
